@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define BPS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bps assertion failed");

// Checked on every rising edge, also during reset.
`define BPS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("bps assertion failed");

`endif

@@ rtl/core/bps_pkg.sv @@
package bps_pkg;

  localparam int RankBits    = 15;
  localparam int StepBits    = 17;
  localparam int BlockBits   = 16;
  localparam int LogBits     = 4;
  localparam int CfgIdxBits  = 1;
  localparam int CfgDataBits = 16;

  // Reciprocal multiply for step mod L: q = (step * ceil(2^22 / L)) >> 22 is exact
  // for every 17-bit step and L up to 15.
  localparam int RecipShift = 22;
  localparam int RecipBits  = 23;
  localparam int ProdBits   = StepBits + RecipBits;

  localparam int FifoDepth   = 4;
  localparam int FifoPtrBits = 2;
  localparam int FifoCntBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgLog2Members = 1'b0,
    CfgBlockCount  = 1'b1
  } bps_cfg_e;

  typedef struct packed {
    logic                req_type;
    logic [RankBits-1:0] rank;
    logic [StepBits-1:0] step;
    logic [LogBits-1:0]  si;
    logic                past_end;
    logic                early;
  } bps_item_t;

  function automatic logic [RecipBits-1:0] recip(input logic [LogBits-1:0] l);
    logic [RecipBits-1:0] m;
    case (l)
      4'd2:    m = 23'd2097152;
      4'd3:    m = 23'd1398102;
      4'd4:    m = 23'd1048576;
      4'd5:    m = 23'd838861;
      4'd6:    m = 23'd699051;
      4'd7:    m = 23'd599187;
      4'd8:    m = 23'd524288;
      4'd9:    m = 23'd466034;
      4'd10:   m = 23'd419431;
      4'd11:   m = 23'd381301;
      4'd12:   m = 23'd349526;
      4'd13:   m = 23'd322639;
      4'd14:   m = 23'd299594;
      4'd15:   m = 23'd279621;
      default: m = 23'd4194304;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/bps_front.sv @@
module bps_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          req_type_i,
  input  logic [bps_pkg::RankBits-1:0]  rank_i,
  input  logic [bps_pkg::StepBits-1:0]  step_i,
  input  logic [bps_pkg::LogBits-1:0]   log2_i,
  input  logic [bps_pkg::StepBits-1:0]  total_i,
  output logic [1:0]                    inflight_o,
  output logic                          push_o,
  output bps_pkg::bps_item_t            item_o
);

  logic                          s1_v_q, s2_v_q;
  logic                          s1_req_q, s2_req_q;
  logic [bps_pkg::RankBits-1:0]  s1_rank_q, s2_rank_q;
  logic [bps_pkg::StepBits-1:0]  s1_step_q, s2_step_q;
  logic [bps_pkg::ProdBits-1:0]  s1_prod_d, s1_prod_q;
  logic [bps_pkg::StepBits-1:0]  quot;
  logic [bps_pkg::StepBits+bps_pkg::LogBits-1:0] ql_full;
  logic [bps_pkg::StepBits-1:0]  s2_ql_q;
  logic [bps_pkg::StepBits-1:0]  rem_full;

  assign s1_prod_d = bps_pkg::ProdBits'(step_i) * bps_pkg::ProdBits'(bps_pkg::recip(log2_i));
  assign quot      = s1_prod_q[bps_pkg::RecipShift +: bps_pkg::StepBits];
  assign ql_full   = quot * log2_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_req_q  <= req_type_i;
    s1_rank_q <= rank_i;
    s1_step_q <= step_i;
    s1_prod_q <= s1_prod_d;
    s2_req_q  <= s1_req_q;
    s2_rank_q <= s1_rank_q;
    s2_step_q <= s1_step_q;
    s2_ql_q   <= ql_full[bps_pkg::StepBits-1:0];
  end

  assign rem_full   = s2_step_q - s2_ql_q;
  assign inflight_o = {1'b0, s1_v_q} + {1'b0, s2_v_q};
  assign push_o     = s2_v_q;

  always_comb begin
    item_o.req_type = s2_req_q;
    item_o.rank     = s2_rank_q;
    item_o.step     = s2_step_q;
    item_o.si       = rem_full[bps_pkg::LogBits-1:0];
    item_o.past_end = (s2_step_q >= total_i);
    item_o.early    = (s2_step_q < bps_pkg::StepBits'(log2_i));
  end

endmodule

@@ rtl/core/bps_fifo.sv @@
module bps_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  bps_pkg::bps_item_t               item_i,
  input  logic                             pop_i,
  output logic                             valid_o,
  output bps_pkg::bps_item_t               item_o,
  output logic [bps_pkg::FifoCntBits-1:0]  count_o
);

  bps_pkg::bps_item_t                  mem_q [bps_pkg::FifoDepth];
  logic [bps_pkg::FifoPtrBits-1:0]     wr_ptr_q, wr_ptr_d;
  logic [bps_pkg::FifoPtrBits-1:0]     rd_ptr_q, rd_ptr_d;
  logic [bps_pkg::FifoCntBits-1:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + bps_pkg::FifoCntBits'(push_i) - bps_pkg::FifoCntBits'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

@@ rtl/core/bps_back.sv @@
module bps_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  bps_pkg::bps_item_t             item_i,
  input  logic [bps_pkg::LogBits-1:0]    log2_i,
  input  logic [bps_pkg::BlockBits-1:0]  block_count_i,
  output logic                           valid_o,
  output logic                           transfer_valid_o,
  output logic [bps_pkg::RankBits-1:0]   peer_rank_o,
  output logic [bps_pkg::BlockBits-1:0]  block_index_o,
  output logic [bps_pkg::StepBits-1:0]   forged_index_o
);

  // Stage one: peer, receiver, rotated receiver and its first block.
  logic [bps_pkg::RankBits-1:0]   other, recv, lmask, rot;
  logic [2*bps_pkg::RankBits-1:0] dbl, shifted;
  logic [bps_pkg::LogBits-1:0]    fb;

  logic                           b1_v_q;
  logic [bps_pkg::RankBits-1:0]   b1_other_q, b1_rot_q;
  logic [bps_pkg::LogBits-1:0]    b1_fb_q;
  logic [bps_pkg::StepBits-1:0]   b1_step_q;
  logic                           b1_kill_q, b1_early_q;

  always_comb begin
    other   = item_i.rank ^ (bps_pkg::RankBits'(1) << item_i.si);
    recv    = item_i.req_type ? item_i.rank : other;
    dbl     = {{bps_pkg::RankBits{1'b0}}, recv} |
              ({{bps_pkg::RankBits{1'b0}}, recv} << log2_i);
    shifted = dbl >> item_i.si;
    // At L equal to the rank width the shift wraps to zero and the mask becomes all ones.
    lmask   = (bps_pkg::RankBits'(1) << log2_i) - 1'b1;
    rot     = shifted[bps_pkg::RankBits-1:0] & lmask;
    fb      = '0;
    for (int i = bps_pkg::RankBits - 1; i >= 0; i--) begin
      if (recv[i]) begin
        fb = bps_pkg::LogBits'(i);
      end
    end
  end

  // Stage two: start-up check and the raw block number.
  logic [bps_pkg::LogBits-1:0]    idx;
  logic [bps_pkg::StepBits:0]     sum;
  logic                           ok_d;
  logic [bps_pkg::StepBits-1:0]   raw_d;

  logic                           b2_v_q, b2_ok_q, b2_clamp_q;
  logic [bps_pkg::RankBits-1:0]   b2_other_q;
  logic [bps_pkg::StepBits-1:0]   b2_raw_q;
  logic [bps_pkg::LogBits-1:0]    b2_fb_q;

  always_comb begin
    idx = log2_i;
    for (int i = bps_pkg::RankBits - 1; i >= 1; i--) begin
      if (b1_rot_q[i]) begin
        idx = bps_pkg::LogBits'(i);
      end
    end
    if (!b1_rot_q[0]) begin
      sum = {1'b0, b1_step_q};
      ok_d = !b1_kill_q && !b1_early_q;
    end else begin
      sum = {1'b0, b1_step_q} + (bps_pkg::StepBits + 1)'(idx);
      ok_d = !b1_kill_q && (sum >= (bps_pkg::StepBits + 1)'(log2_i));
    end
    raw_d = bps_pkg::StepBits'(sum - (bps_pkg::StepBits + 1)'(log2_i));
  end

  // Stage three: clamp to the last block and pick the tag number.
  logic [bps_pkg::BlockBits-1:0]  last;
  logic [bps_pkg::StepBits-1:0]   blk, forged;

  always_comb begin
    last = (block_count_i != '0) ? block_count_i - 1'b1 : '0;
    if (b2_clamp_q) begin
      blk    = (b2_raw_q < {1'b0, last}) ? b2_raw_q : {1'b0, last};
      forged = (b2_raw_q != bps_pkg::StepBits'(b2_fb_q)) ? blk : b2_raw_q;
    end else begin
      blk    = b2_raw_q;
      forged = b2_raw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      b1_v_q  <= in_valid_i;
      b2_v_q  <= b1_v_q;
      valid_o <= b2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_other_q <= other;
    b1_rot_q   <= rot;
    b1_fb_q    <= fb;
    b1_step_q  <= item_i.step;
    b1_kill_q  <= item_i.past_end || (recv == '0);
    b1_early_q <= item_i.early;

    b2_ok_q    <= ok_d;
    b2_clamp_q <= b1_rot_q[0];
    b2_other_q <= b1_other_q;
    b2_raw_q   <= raw_d;
    b2_fb_q    <= b1_fb_q;

    transfer_valid_o <= b2_ok_q;
    peer_rank_o      <= b2_ok_q ? b2_other_q : '0;
    block_index_o    <= b2_ok_q ? blk[bps_pkg::BlockBits-1:0] : '0;
    forged_index_o   <= b2_ok_q ? forged : '0;
  end

endmodule

@@ rtl/core/binomial_pipeline_schedule.sv @@
// Binomial pipeline multicast schedule query.
// A query beat is taken on a rising edge with start_i high and busy_o low. It carries
// req_type_i (0 outgoing, 1 incoming), rank_i and step_i. Every query yields exactly one
// result beat, shown for one cycle with valid_o high: transfer_valid_o, peer_rank_o,
// block_index_o and forged_index_o. Fields are zero when no transfer happens.
// One query can be taken every cycle; the front computes step mod L with a reciprocal
// multiply in two stages, a four-entry queue follows, and the back resolves the block
// numbers in three stages.
// busy_o rises only when the queue plus the front stages hold four beats; since the back
// drains the queue every cycle, that never happens and busy_o stays low.
// The receiver cannot stall; results are never held back.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 log2_members,
// 1 block_count) on that edge. Write only while no query is in flight.
// Reset clears the pipeline and queue and sets log2_members and block_count to one.
`include "assert_macros.svh"

module binomial_pipeline_schedule (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              req_type_i,
  input  logic [bps_pkg::RankBits-1:0]      rank_i,
  input  logic [bps_pkg::StepBits-1:0]      step_i,
  input  logic                              cfg_we_i,
  input  logic [bps_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [bps_pkg::CfgDataBits-1:0]   cfg_wdata_i,
  output logic                              valid_o,
  output logic                              transfer_valid_o,
  output logic [bps_pkg::RankBits-1:0]      peer_rank_o,
  output logic [bps_pkg::BlockBits-1:0]     block_index_o,
  output logic [bps_pkg::StepBits-1:0]      forged_index_o
);

  logic [bps_pkg::LogBits-1:0]     log2_q;
  logic [bps_pkg::BlockBits-1:0]   block_count_q;
  logic [bps_pkg::LogBits-1:0]     log2_eff;
  logic [bps_pkg::StepBits-1:0]    total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_q        <= bps_pkg::LogBits'(1);
      block_count_q <= bps_pkg::BlockBits'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bps_pkg::CfgLog2Members: log2_q        <= cfg_wdata_i[bps_pkg::LogBits-1:0];
        bps_pkg::CfgBlockCount:  block_count_q <= cfg_wdata_i[bps_pkg::BlockBits-1:0];
        default: ;
      endcase
    end
  end

  // A group size code of zero behaves as one.
  assign log2_eff = (log2_q == '0) ? bps_pkg::LogBits'(1) : log2_q;
  assign total    = {1'b0, block_count_q} + bps_pkg::StepBits'(log2_eff) - 1'b1;

  logic                              accept;
  logic [1:0]                        inflight;
  logic                              fifo_push, fifo_pop, fifo_valid;
  bps_pkg::bps_item_t                push_item, pop_item;
  logic [bps_pkg::FifoCntBits-1:0]   fifo_count;
  logic [bps_pkg::FifoCntBits-1:0]   reserved;

  assign reserved = fifo_count + bps_pkg::FifoCntBits'(inflight);
  assign busy_o   = (reserved >= bps_pkg::FifoCntBits'(bps_pkg::FifoDepth));
  assign accept   = start_i && !busy_o;
  assign fifo_pop = fifo_valid;

  bps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .rank_i     (rank_i),
    .step_i     (step_i),
    .log2_i     (log2_eff),
    .total_i    (total),
    .inflight_o (inflight),
    .push_o     (fifo_push),
    .item_o     (push_item)
  );

  bps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .item_i  (push_item),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .item_o  (pop_item),
    .count_o (fifo_count)
  );

  bps_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (fifo_pop),
    .item_i           (pop_item),
    .log2_i           (log2_eff),
    .block_count_i    (block_count_q),
    .valid_o          (valid_o),
    .transfer_valid_o (transfer_valid_o),
    .peer_rank_o      (peer_rank_o),
    .block_index_o    (block_index_o),
    .forged_index_o   (forged_index_o)
  );

  `BPS_ASSERT(a_no_overflow, clk_i, rst_ni, (fifo_push && !fifo_pop) |-> (fifo_count < bps_pkg::FifoCntBits'(bps_pkg::FifoDepth)))
  `BPS_ASSERT(a_reserve_bound, clk_i, rst_ni, reserved <= bps_pkg::FifoCntBits'(bps_pkg::FifoDepth))
  `BPS_ASSERT(a_invalid_zero, clk_i, rst_ni, (valid_o && !transfer_valid_o) |-> (peer_rank_o == '0 && block_index_o == '0 && forged_index_o == '0))

endmodule

@@ tb/sv/tb_binomial_pipeline_schedule.sv @@
`timescale 1ns / 1ps

module tb_binomial_pipeline_schedule;
  import bps_pkg::*;

  localparam logic ReqOut = 1'b0;
  localparam logic ReqIn  = 1'b1;

  localparam int DrainCycles = 8;
  localparam int RandPhases  = 12;
  localparam int PhaseItems  = 120;
  localparam int MaxGap      = 8;

  localparam longint unsigned RankMask = (64'd1 << RankBits) - 64'd1;

  typedef struct packed {
    logic                 transfer_valid;
    logic [RankBits-1:0]  peer_rank;
    logic [BlockBits-1:0] block_index;
    logic [StepBits-1:0]  forged_index;
  } transfer_t;

  localparam transfer_t NoTransfer = '0;

  // One directed query; the settings are written first whenever they differ from the
  // current ones. Rows with fixed set carry their own expectation.
  typedef struct packed {
    logic [CfgDataBits-1:0] log2_word;
    logic [BlockBits-1:0]   blocks;
    logic                   req;
    logic [RankBits-1:0]    rank;
    logic [StepBits-1:0]    step;
    logic                   fixed;
    transfer_t              want;
  } probe_t;

  localparam probe_t Probes [0:23] = '{
    // Settings straight out of reset: one step, one block.
    '{16'd1, 16'd1, ReqIn,  15'd1,     17'd0,      1'b1, '{1'b1, 15'd0, 16'd0, 17'd0}},
    '{16'd1, 16'd1, ReqOut, 15'd0,     17'd0,      1'b1, '{1'b1, 15'd1, 16'd0, 17'd0}},
    '{16'd1, 16'd1, ReqIn,  15'd0,     17'd0,      1'b1, NoTransfer},
    '{16'd1, 16'd1, ReqOut, 15'd32767, 17'd131071, 1'b1, NoTransfer},
    '{16'd1, 16'd1, ReqIn,  15'd32767, 17'd1,      1'b1, NoTransfer},
    // Largest group and longest message.
    '{16'd15, 16'd65535, ReqOut, 15'd32767, 17'd0,      1'b1, NoTransfer},
    '{16'd15, 16'd65535, ReqIn,  15'd32767, 17'd131071, 1'b1, NoTransfer},
    '{16'd15, 16'd65535, ReqIn,  15'd16384, 17'd20,     1'b0, NoTransfer},
    '{16'd15, 16'd65535, ReqOut, 15'd1,     17'd65548,  1'b0, NoTransfer},
    '{16'd15, 16'd65535, ReqIn,  15'd32767, 17'd65549,  1'b1, NoTransfer},
    '{16'd15, 16'd65535, ReqOut, 15'd12345, 17'd100,    1'b0, NoTransfer},
    // Mid-size group: start-up steps, clamping near the last block, ranks above L bits.
    '{16'd4, 16'd10, ReqIn,  15'd2,  17'd0,  1'b1, NoTransfer},
    '{16'd4, 16'd10, ReqIn,  15'd1,  17'd3,  1'b0, NoTransfer},
    '{16'd4, 16'd10, ReqOut, 15'd5,  17'd7,  1'b0, NoTransfer},
    '{16'd4, 16'd10, ReqIn,  15'd15, 17'd12, 1'b0, NoTransfer},
    '{16'd4, 16'd10, ReqOut, 15'd16, 17'd4,  1'b0, NoTransfer},
    // A zero group size behaves as a single bit.
    '{16'd0, 16'd5, ReqIn,  15'd1, 17'd2, 1'b0, NoTransfer},
    '{16'd0, 16'd5, ReqOut, 15'd3, 17'd4, 1'b0, NoTransfer},
    '{16'd0, 16'd5, ReqIn,  15'd0, 17'd0, 1'b1, NoTransfer},
    // A zero block count shortens the schedule to L - 1 steps; the last two rows use L = 2 and three blocks.
    '{16'd3, 16'd0, ReqIn,  15'd7, 17'd1, 1'b0, NoTransfer},
    '{16'd3, 16'd0, ReqOut, 15'd4, 17'd0, 1'b0, NoTransfer},
    '{16'd3, 16'd0, ReqIn,  15'd6, 17'd2, 1'b1, NoTransfer},
    '{16'd2, 16'd3, ReqIn,  15'd3, 17'd2, 1'b0, NoTransfer},
    '{16'd2, 16'd3, ReqOut, 15'd1, 17'd3, 1'b0, NoTransfer}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic                   req_type_i;
  logic [RankBits-1:0]    rank_i;
  logic [StepBits-1:0]    step_i;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_wdata_i;
  logic                   valid_o;
  logic                   transfer_valid_o;
  logic [RankBits-1:0]    peer_rank_o;
  logic [BlockBits-1:0]   block_index_o;
  logic [StepBits-1:0]    forged_index_o;

  logic [LogBits-1:0]   cfg_log2;
  logic [BlockBits-1:0] cfg_blocks;
  transfer_t            pending_transfers [$];

  int errors;
  int queries_sent;
  int results_checked;
  int transfers_seen;
  int settings_used;

  binomial_pipeline_schedule dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .rank_i           (rank_i),
    .step_i           (step_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .valid_o          (valid_o),
    .transfer_valid_o (transfer_valid_o),
    .peer_rank_o      (peer_rank_o),
    .block_index_o    (block_index_o),
    .forged_index_o   (forged_index_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Works out the transfer for one query under the current settings.
  function automatic transfer_t schedule_transfer(input logic incoming,
                                                  input logic [RankBits-1:0] rank,
                                                  input logic [StepBits-1:0] step);
    transfer_t       res;
    longint unsigned span, last_blk, total, s, si, other, recv;
    longint unsigned rot, idx, forged, blk, first, b;
    res = NoTransfer;
    span = (cfg_log2 == '0) ? 64'd1 : 64'(cfg_log2);
    last_blk = (cfg_blocks == '0) ? 64'd0 : 64'(cfg_blocks) - 64'd1;
    total = 64'(cfg_blocks) + span - 64'd1;
    s = 64'(step);
    si = s % span;
    other = (64'(rank) ^ (64'd1 << si)) & RankMask;
    recv = incoming ? 64'(rank) : other;
    if (s >= total || recv == 64'd0) return res;
    rot = ((recv | (recv << span)) >> si) & ((64'd1 << span) - 64'd1);
    if (!rot[0]) begin
      if (s < span) return res;
      forged = s - span;
      blk = forged;
    end else begin
      idx = span;
      for (b = span - 64'd1; b >= 64'd1; b--) begin
        if (rot[b]) idx = b;
      end
      if (s + idx < span) return res;
      forged = s + idx - span;
      blk = (forged < last_blk) ? forged : last_blk;
      // The tag keeps the unclamped number only for the receiver's first block.
      first = 64'd0;
      for (b = 64'd16; b > 64'd0; b--) begin
        if (recv[b - 64'd1]) first = b - 64'd1;
      end
      if (forged != first) forged = blk;
    end
    res.transfer_valid = 1'b1;
    res.peer_rank      = RankBits'(other);
    res.block_index    = BlockBits'(blk);
    res.forged_index   = StepBits'(forged);
    return res;
  endfunction

  task automatic issue_query(input logic req, input logic [RankBits-1:0] rank,
                             input logic [StepBits-1:0] step, input int gap,
                             input logic fixed, input transfer_t want);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    req_type_i <= req;
    rank_i     <= rank;
    step_i     <= step;
    do @(posedge clk_i); while (busy_o);
    pending_transfers.push_back(fixed ? want : schedule_transfer(req, rank, step));
    queries_sent++;
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_transfers.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_settings(input logic [CfgDataBits-1:0] log2_word,
                                input logic [BlockBits-1:0] blocks);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgLog2Members;
    cfg_wdata_i <= log2_word;
    @(posedge clk_i);
    cfg_log2 = log2_word[LogBits-1:0];
    cfg_idx_i   <= CfgBlockCount;
    cfg_wdata_i <= blocks;
    @(posedge clk_i);
    cfg_blocks = blocks;
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  always @(posedge clk_i) begin
    transfer_t want;
    if (rst_ni && valid_o) begin
      if (pending_transfers.size() == 0) begin
        $error("result beat with no query outstanding");
        errors++;
      end else begin
        want = pending_transfers.pop_front();
        results_checked++;
        if (transfer_valid_o) transfers_seen++;
        if (transfer_valid_o !== want.transfer_valid) begin
          $error("transfer_valid: expected %0d, got %0d", want.transfer_valid,
                 transfer_valid_o);
          errors++;
        end
        if (peer_rank_o !== want.peer_rank) begin
          $error("peer_rank: expected %0d, got %0d", want.peer_rank, peer_rank_o);
          errors++;
        end
        if (block_index_o !== want.block_index) begin
          $error("block_index: expected %0d, got %0d", want.block_index, block_index_o);
          errors++;
        end
        if (forged_index_o !== want.forged_index) begin
          $error("forged_index: expected %0d, got %0d", want.forged_index,
                 forged_index_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int                     phase;
    int                     k;
    int                     span;
    int                     total;
    int                     rank_hi;
    int                     gap_max;
    int                     pick;
    logic [CfgDataBits-1:0] log2_word;
    logic [BlockBits-1:0]   blocks;
    logic                   q_req;
    logic [RankBits-1:0]    q_rank;
    logic [StepBits-1:0]    q_step;

    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    req_type_i  <= ReqOut;
    rank_i      <= '0;
    step_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CfgLog2Members;
    cfg_wdata_i <= '0;
    cfg_log2 = LogBits'(1);
    cfg_blocks = BlockBits'(1);
    errors = 0;
    queries_sent = 0;
    results_checked = 0;
    transfers_seen = 0;
    settings_used = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < 24; k++) begin
      if (Probes[k].log2_word[LogBits-1:0] != cfg_log2 || Probes[k].blocks != cfg_blocks)
      begin
        wait_idle();
        write_settings(Probes[k].log2_word, Probes[k].blocks);
      end
      issue_query(Probes[k].req, Probes[k].rank, Probes[k].step,
                  int'($urandom_range(MaxGap, 0)), Probes[k].fixed, Probes[k].want);
    end

    for (phase = 0; phase < RandPhases; phase++) begin
      // The upper bits of the group-size word are don't-care and get random values.
      log2_word = {12'($urandom), 4'($urandom_range(15, 1))};
      case (phase)
        0: begin
          log2_word[3:0] = 4'd15;
          blocks = 16'd65535;
        end
        1: begin
          log2_word[3:0] = 4'd1;
          blocks = 16'd1;
        end
        2: begin
          log2_word[3:0] = 4'd0;
          blocks = 16'($urandom_range(20, 2));
        end
        3: begin
          blocks = 16'd0;
        end
        4: begin
          log2_word[3:0] = 4'd1;
          blocks = 16'd65535;
        end
        5: begin
          log2_word[3:0] = 4'd15;
          blocks = 16'd1;
        end
        default: begin
          blocks = (phase % 2 == 1) ? 16'($urandom_range(40, 1))
                                    : 16'($urandom_range(65535, 1));
        end
      endcase
      wait_idle();
      write_settings(log2_word, blocks);
      span = (log2_word[3:0] == 4'd0) ? 1 : int'(log2_word[3:0]);
      total = int'(blocks) + span - 1;
      rank_hi = (2 << span) - 1;
      if (rank_hi > 32767) rank_hi = 32767;
      gap_max = (phase % 3 == 1) ? 0 : MaxGap;
      for (k = 0; k < PhaseItems; k++) begin
        q_req = 1'($urandom);
        pick = int'($urandom_range(99, 0));
        q_rank = (pick < 85) ? 15'($urandom_range(rank_hi, 0)) : 15'($urandom);
        pick = int'($urandom_range(99, 0));
        if (pick < 80) begin
          q_step = (total > 0) ? 17'($urandom_range(total - 1, 0)) : 17'd0;
        end else if (pick < 90) begin
          q_step = 17'(total + int'($urandom_range(3, 0)));
        end else begin
          q_step = 17'($urandom);
        end
        issue_query(q_req, q_rank, q_step, int'($urandom_range(gap_max, 0)), 1'b0,
                    NoTransfer);
      end
    end

    wait_idle();
    $display("Sent %0d schedule queries under %0d register settings.", queries_sent,
             settings_used);
    $display("Checked %0d result beats, %0d of them with a transfer.", results_checked,
             transfers_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d results still outstanding.", pending_transfers.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
